>>> hw/rtl/sfd_pkg.sv
// package with types, constants and codes of the serial frame deframer filter
`default_nettype none

package sfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ChanW    = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ByteW-1:0] FlagByte  = 8'h7E;
  localparam logic [ByteW-1:0] ChanBcast = 8'hFF;
  localparam logic [ByteW-1:0] CodeBcast = 8'hAF;
  localparam logic [ByteW-1:0] ChanNew   = 8'hFE;
  localparam logic [ByteW-1:0] CodeNew   = 8'hBF;
  localparam logic [ByteW-1:0] HeaderLen = 8'd5;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OWN_CHANNEL       = 2'd0,
    REG_OWN_CHANNEL_VALID = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLASS_REJECT = 2'd0,
    CLASS_BCAST  = 2'd1,
    CLASS_NEW    = 2'd2,
    CLASS_OWN    = 2'd3
  } addr_class_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_SUMMARY = 1'b1
  } result_kind_t;

  typedef enum logic [8:0] {
    ST_UNSYNC  = 9'b000000001,
    ST_START   = 9'b000000010,
    ST_LEN     = 9'b000000100,
    ST_CHAN    = 9'b000001000,
    ST_BCAST   = 9'b000010000,
    ST_TYPE    = 9'b000100000,
    ST_PAYLOAD = 9'b001000000,
    ST_CHECK   = 9'b010000000,
    ST_END     = 9'b100000000
  } parse_state_t;

  typedef struct packed {
    logic [ChanW-1:0] own_channel;
    logic             own_channel_valid;
  } cfg_t;

  typedef struct packed {
    result_kind_t     result_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] frame_length;
    logic [ByteW-1:0] channel_id;
    logic [ByteW-1:0] broadcast_code;
    logic [ByteW-1:0] message_type;
    logic [ByteW-1:0] check_byte;
    addr_class_t      address_class;
    logic             end_flag_ok;
  } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/sfd_byte_if.sv
// valid/ready channel carrying one received serial byte
`default_nettype none

interface sfd_byte_if;
  logic                      valid;
  logic                      ready;
  logic [sfd_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sfd_result_if.sv
// valid/ready channel carrying one payload byte or frame summary
`default_nettype none

interface sfd_result_if;
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [sfd_pkg::ByteW-1:0] payload_byte;
  logic [sfd_pkg::ByteW-1:0] frame_length;
  logic [sfd_pkg::ByteW-1:0] channel_id;
  logic [sfd_pkg::ByteW-1:0] broadcast_code;
  logic [sfd_pkg::ByteW-1:0] message_type;
  logic [sfd_pkg::ByteW-1:0] check_byte;
  logic [1:0]                address_class;
  logic                      end_flag_ok;

  modport source (
    output valid, input ready, output result_kind, output payload_byte,
    output frame_length, output channel_id, output broadcast_code,
    output message_type, output check_byte, output address_class, output end_flag_ok
  );
  modport sink (
    input valid, output ready, input result_kind, input payload_byte,
    input frame_length, input channel_id, input broadcast_code,
    input message_type, input check_byte, input address_class, input end_flag_ok
  );
endinterface

`default_nettype wire

>>> hw/rtl/sfd_cfg_if.sv
// valid/ready register write channel
`default_nettype none

interface sfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sfd_pkg::CfgIdxW-1:0]  index;
  logic [sfd_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/serial_frame_deframer_filter.sv
// top level of the serial frame deframer filter
//
// rx carries one received serial byte per transaction. the block hunts for
// two '~' bytes, holds length, channel, broadcast code and type, classifies
// the frame and passes payload bytes of accepted frames out on res as they
// arrive, followed by one summary transaction at the end byte. a bad end
// byte still closes the frame and the block goes back to hunting.
// cfg writes own_channel (index 0) and own_channel_valid (index 1); it is
// always ready. the user must write it only while the block is idle; the
// block itself does not enforce this. a byte taken on rx reaches res through
// the input register, a combinational parse step and the two-entry result
// buffer; throughput is one byte per cycle while res keeps up.
// when res stalls, the buffer absorbs up to two results, then the input
// register holds its byte and rx.ready drops until res drains.
// reset (rst, synchronous) clears the buffer, the input register and puts
// the parser in the hunting state with cleared fields and registers.
`default_nettype none

module serial_frame_deframer_filter (
  input  wire logic clk,
  input  wire logic rst,
  sfd_byte_if.sink   rx,
  sfd_result_if.source res,
  sfd_cfg_if.sink    cfg
);
  import sfd_pkg::*;

  cfg_t             cfg_regs;
  logic             held_valid;
  logic [ByteW-1:0] held_byte;
  logic             can_push;
  logic             advance;
  logic             res_push;
  result_t          res_next;
  result_t          res_out;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_OWN_CHANNEL:       cfg_regs.own_channel <= cfg.data[ChanW-1:0];
        REG_OWN_CHANNEL_VALID: cfg_regs.own_channel_valid <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign advance = held_valid && can_push;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (rx.valid),
    .in_ready   (rx.ready),
    .in_byte    (rx.rx_byte),
    .take       (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  sfd_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .advance  (advance),
    .rx_byte  (held_byte),
    .res_push (res_push),
    .res      (res_next)
  );

  sfd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_next),
    .can_push  (can_push),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res_out)
  );

  assign res.result_kind    = res_out.result_kind;
  assign res.payload_byte   = res_out.payload_byte;
  assign res.frame_length   = res_out.frame_length;
  assign res.channel_id     = res_out.channel_id;
  assign res.broadcast_code = res_out.broadcast_code;
  assign res.message_type   = res_out.message_type;
  assign res.check_byte     = res_out.check_byte;
  assign res.address_class  = res_out.address_class;
  assign res.end_flag_ok    = res_out.end_flag_ok;

endmodule

`default_nettype wire

>>> hw/rtl/sfd_in_stage.sv
// input register holding one received byte until the parser takes it
`default_nettype none

module sfd_in_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [sfd_pkg::ByteW-1:0] in_byte,
  input  wire logic                      take,
  output logic                           held_valid,
  output logic [sfd_pkg::ByteW-1:0]      held_byte
);
  import sfd_pkg::*;

  logic             full;
  logic [ByteW-1:0] data;

  assign in_ready   = !full || take;
  assign held_valid = full;
  assign held_byte  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_byte;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sfd_parser.sv
// frame parse state machine, held header fields and result forming
`default_nettype none

module sfd_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sfd_pkg::cfg_t             cfg,
  input  wire logic                      advance,
  input  wire logic [sfd_pkg::ByteW-1:0] rx_byte,
  output logic                           res_push,
  output sfd_pkg::result_t               res
);
  import sfd_pkg::*;

  parse_state_t     state, state_next;
  logic [ByteW-1:0] held_length, held_length_next;
  logic [ByteW-1:0] held_channel, held_channel_next;
  logic [ByteW-1:0] held_broadcast, held_broadcast_next;
  logic [ByteW-1:0] held_type, held_type_next;
  logic [ByteW-1:0] payload_count, payload_count_next;
  logic [ByteW-1:0] held_check, held_check_next;
  addr_class_t      held_class, held_class_next;
  logic             emit;
  logic             is_flag;

  function automatic addr_class_t classify(input logic [ByteW-1:0] chan,
                                           input logic [ByteW-1:0] code,
                                           input cfg_t c);
    addr_class_t r;
    if (chan == ChanBcast && code == CodeBcast) begin
      r = CLASS_BCAST;
    end else if (chan == ChanNew && code == CodeNew) begin
      r = CLASS_NEW;
    end else if (c.own_channel_valid && chan == {{(ByteW-ChanW){1'b0}}, c.own_channel}) begin
      r = CLASS_OWN;
    end else begin
      r = CLASS_REJECT;
    end
    return r;
  endfunction

  assign is_flag  = (rx_byte == FlagByte);
  assign res_push = advance && emit;

  always_comb begin
    state_next          = state;
    held_length_next    = held_length;
    held_channel_next   = held_channel;
    held_broadcast_next = held_broadcast;
    held_type_next      = held_type;
    payload_count_next  = payload_count;
    held_check_next     = held_check;
    held_class_next     = held_class;
    emit                = 1'b0;
    res                 = '0;
    case (state)
      ST_UNSYNC: begin
        if (is_flag) state_next = ST_START;
      end
      ST_START: begin
        if (is_flag) begin
          held_length_next    = '0;
          held_channel_next   = '0;
          held_broadcast_next = '0;
          held_type_next      = '0;
          payload_count_next  = '0;
          held_check_next     = '0;
          held_class_next     = CLASS_REJECT;
          state_next          = ST_LEN;
        end else begin
          state_next = ST_UNSYNC;
        end
      end
      ST_LEN: begin
        held_length_next = rx_byte;
        state_next       = ST_CHAN;
      end
      ST_CHAN: begin
        held_channel_next = rx_byte;
        state_next        = ST_BCAST;
      end
      ST_BCAST: begin
        held_broadcast_next = rx_byte;
        held_class_next     = classify(held_channel, rx_byte, cfg);
        state_next          = ST_TYPE;
      end
      ST_TYPE: begin
        held_type_next = rx_byte;
        state_next     = (held_length <= HeaderLen) ? ST_CHECK : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        payload_count_next = payload_count + 8'd1;
        if (payload_count_next >= held_length - HeaderLen) state_next = ST_CHECK;
        if (held_class != CLASS_REJECT) begin
          emit             = 1'b1;
          res.result_kind  = KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
      ST_CHECK: begin
        held_check_next = rx_byte;
        state_next      = ST_END;
      end
      ST_END: begin
        emit               = 1'b1;
        res.result_kind    = KIND_SUMMARY;
        res.frame_length   = held_length;
        res.channel_id     = held_channel;
        res.broadcast_code = held_broadcast;
        res.message_type   = held_type;
        res.check_byte     = held_check;
        res.address_class  = held_class;
        res.end_flag_ok    = is_flag;
        state_next         = is_flag ? ST_START : ST_UNSYNC;
      end
      default: begin
        state_next = ST_UNSYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_UNSYNC;
      held_length    <= '0;
      held_channel   <= '0;
      held_broadcast <= '0;
      held_type      <= '0;
      payload_count  <= '0;
      held_check     <= '0;
      held_class     <= CLASS_REJECT;
    end else if (advance) begin
      state          <= state_next;
      held_length    <= held_length_next;
      held_channel   <= held_channel_next;
      held_broadcast <= held_broadcast_next;
      held_type      <= held_type_next;
      payload_count  <= payload_count_next;
      held_check     <= held_check_next;
      held_class     <= held_class_next;
    end
  end

  // payload state is only reached with a length longer than the header
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAYLOAD |-> held_length > HeaderLen)
    else $error("payload state with short length");

  // a fresh frame starts with cleared held fields
  a_len_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_LEN |-> (payload_count == '0 && held_class == CLASS_REJECT
                         && held_check == '0))
    else $error("held fields not cleared at frame start");

  // rejected frames give no payload transactions
  a_no_reject_payload: assert property (@(posedge clk) disable iff (rst)
    res_push && res.result_kind == KIND_PAYLOAD |-> held_class != CLASS_REJECT)
    else $error("payload of rejected frame passed out");

  // a good end flag resynchronizes onto the next start flag
  a_end_flag: assert property (@(posedge clk) disable iff (rst)
    advance && state == ST_END && is_flag |=> state == ST_START)
    else $error("end flag not taken as next start");

endmodule

`default_nettype wire

>>> hw/rtl/sfd_out_fifo.sv
// two-entry result buffer between parser and result channel
`default_nettype none

module sfd_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire sfd_pkg::result_t push_data,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output sfd_pkg::result_t      out_data
);
  import sfd_pkg::*;

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign can_push  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_serial_frame_deframer_filter.sv
// testbench for the serial frame deframer filter: random framed byte streams checked against a built-in deframer
`timescale 1ns / 1ps

module tb_serial_frame_deframer_filter;
  import sfd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBytes = 80;

  logic clk;
  logic rst;

  sfd_byte_if   rx_if ();
  sfd_result_if res_if ();
  sfd_cfg_if    cfg_if ();

  serial_frame_deframer_filter dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .res(res_if),
    .cfg(cfg_if)
  );

  logic [7:0]  rx_stream[$];
  result_t     due_results[$];
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  bit          rx_taken   = 1'b0;
  bit          idle_on    = 1'b1;
  bit          hold_off   = 1'b0;
  int unsigned gap_cnt    = 0;
  int unsigned stall_cnt  = 0;

  // deframer model state
  parse_state_t     p_state  = ST_UNSYNC;
  logic [7:0]       f_len    = '0;
  logic [7:0]       f_chan   = '0;
  logic [7:0]       f_bcast  = '0;
  logic [7:0]       f_type   = '0;
  logic [7:0]       f_cnt    = '0;
  logic [7:0]       f_check  = '0;
  addr_class_t      f_class  = CLASS_REJECT;
  logic [ChanW-1:0] m_own    = '0;
  logic             m_own_ok = 1'b0;

  // stream generator state
  logic [ChanW-1:0] gen_own          = '0;
  bit               gen_flag_pending = 1'b0;
  int unsigned      long_cnt         = 0;

  function automatic void deframe_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (p_state)
      ST_UNSYNC: begin
        if (b == FlagByte) p_state = ST_START;
      end
      ST_START: begin
        if (b == FlagByte) begin
          {f_len, f_chan, f_bcast, f_type, f_cnt, f_check} = '0;
          f_class = CLASS_REJECT;
          p_state = ST_LEN;
        end else begin
          p_state = ST_UNSYNC;
        end
      end
      ST_LEN: begin
        f_len   = b;
        p_state = ST_CHAN;
      end
      ST_CHAN: begin
        f_chan  = b;
        p_state = ST_BCAST;
      end
      ST_BCAST: begin
        f_bcast = b;
        if (f_chan == ChanBcast && b == CodeBcast) f_class = CLASS_BCAST;
        else if (f_chan == ChanNew && b == CodeNew) f_class = CLASS_NEW;
        else if (m_own_ok && f_chan == {2'b00, m_own}) f_class = CLASS_OWN;
        else f_class = CLASS_REJECT;
        p_state = ST_TYPE;
      end
      ST_TYPE: begin
        f_type = b;
        if (f_len <= HeaderLen) p_state = ST_CHECK;
        else p_state = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        f_cnt = f_cnt + 8'd1;
        if (f_cnt >= f_len - HeaderLen) p_state = ST_CHECK;
        if (f_class != CLASS_REJECT) begin
          r.result_kind  = KIND_PAYLOAD;
          r.payload_byte = b;
          due_results = {due_results, r};
        end
      end
      ST_CHECK: begin
        f_check = b;
        p_state = ST_END;
      end
      ST_END: begin
        r.result_kind    = KIND_SUMMARY;
        r.frame_length   = f_len;
        r.channel_id     = f_chan;
        r.broadcast_code = f_bcast;
        r.message_type   = f_type;
        r.check_byte     = f_check;
        r.address_class  = f_class;
        r.end_flag_ok    = (b == FlagByte);
        due_results = {due_results, r};
        if (b == FlagByte) p_state = ST_START;
        else p_state = ST_UNSYNC;
      end
      default: p_state = ST_UNSYNC;
    endcase
  endfunction

  function automatic string fmt_res(input result_t r);
    return $sformatf("kind %0d byte %h len %h chan %h bcast %h type %h check %h class %0d flag %0d",
                     r.result_kind, r.payload_byte, r.frame_length, r.channel_id,
                     r.broadcast_code, r.message_type, r.check_byte, r.address_class,
                     r.end_flag_ok);
  endfunction

  function automatic logic [7:0] non_flag();
    logic [7:0] b;
    b = 8'($urandom);
    if (b == FlagByte) b = ~FlagByte;
    return b;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // byte sender
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_taken) begin
      if (gap_cnt > 0) begin
        gap_cnt--;
        rx_if.valid <= 1'b0;
      end else if (hold_off || rx_stream.size() == 0) begin
        rx_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        gap_cnt = $urandom_range(0, 7);
        rx_if.valid <= 1'b0;
      end else begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_stream.pop_front();
      end
    end
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
      res_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(0, 7);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor_blk
    result_t got;
    result_t want;
    if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= rx_if.valid && rx_if.ready;
      if (res_if.valid && res_if.ready) begin
        got.result_kind    = result_kind_t'(res_if.result_kind);
        got.payload_byte   = res_if.payload_byte;
        got.frame_length   = res_if.frame_length;
        got.channel_id     = res_if.channel_id;
        got.broadcast_code = res_if.broadcast_code;
        got.message_type   = res_if.message_type;
        got.check_byte     = res_if.check_byte;
        got.address_class  = addr_class_t'(res_if.address_class);
        got.end_flag_ok    = res_if.end_flag_ok;
        if (due_results.size() == 0) begin
          if (err_cnt < 10) $display("unexpected transaction: %s", fmt_res(got));
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.result_kind !== want.result_kind || got.payload_byte !== want.payload_byte ||
              got.frame_length !== want.frame_length || got.channel_id !== want.channel_id ||
              got.broadcast_code !== want.broadcast_code ||
              got.message_type !== want.message_type || got.check_byte !== want.check_byte ||
              got.address_class !== want.address_class ||
              got.end_flag_ok !== want.end_flag_ok) begin
            if (err_cnt < 10) begin
              $display("mismatch at cycle %0d", cycle_cnt);
              $display("  expected %s", fmt_res(want));
              $display("  actual   %s", fmt_res(got));
            end
            err_cnt++;
          end
        end
      end
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte);
        taken_cnt <= taken_cnt + 1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_t'(cfg_if.index))
          REG_OWN_CHANNEL:       m_own = cfg_if.data[ChanW-1:0];
          REG_OWN_CHANNEL_VALID: m_own_ok = cfg_if.data[0];
          default: ;
        endcase
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    rx_stream = {rx_stream, b};
    queued_cnt++;
  endtask

  task automatic send_header(input logic [7:0] len, input logic [7:0] chan,
                             input logic [7:0] code);
    // a '~' end byte already counts as the first start flag
    if (!gen_flag_pending) push_byte(FlagByte);
    push_byte(FlagByte);
    push_byte(len);
    push_byte(chan);
    push_byte(code);
    gen_flag_pending = 1'b0;
  endtask

  task automatic send_tail(input logic [7:0] len, input bit flag_end);
    push_byte(8'($urandom));
    if (len > HeaderLen) begin
      for (int i = 0; i < len - HeaderLen; i++) push_byte(8'($urandom));
    end
    push_byte(8'($urandom));
    push_byte(flag_end ? FlagByte : non_flag());
    gen_flag_pending = flag_end;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] chan,
                            input logic [7:0] code, input bit flag_end);
    send_header(len, chan, code);
    send_tail(len, flag_end);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] d);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [ChanW-1:0] own, input logic ok);
    logic [7:0] d;
    d = 8'($urandom);
    d[ChanW-1:0] = own;
    write_reg(REG_OWN_CHANNEL, d);
    d = 8'($urandom);
    d[0] = ok;
    write_reg(REG_OWN_CHANNEL_VALID, d);
    gen_own = own;
    @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    while (taken_cnt != queued_cnt || due_results.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic random_chunk();
    int unsigned pick;
    int unsigned n;
    logic [7:0]  len;
    logic [7:0]  chan;
    logic [7:0]  code;
    pick = $urandom_range(0, 19);
    chan = 8'($urandom);
    code = 8'($urandom);
    n    = $urandom_range(0, 99);
    if (n < 85) begin
      len = 8'($urandom_range(0, 16));
    end else if (n < 98 || long_cnt >= 3) begin
      len = 8'($urandom_range(17, 64));
    end else begin
      len = 8'($urandom_range(200, 255));
      long_cnt++;
    end
    if (pick < 16) begin
      case ($urandom_range(0, 5))
        0: begin chan = ChanBcast; code = CodeBcast; end
        1: begin chan = ChanNew; code = CodeNew; end
        2: chan = {2'b00, gen_own};
        3: chan = $urandom_range(0, 1) ? ChanBcast : ChanNew;
        4: chan[ChanW-1:0] = gen_own;
        default: ;
      endcase
      send_frame(len, chan, code, $urandom_range(0, 3) != 0);
    end else if (pick < 18) begin
      // line noise
      n = $urandom_range(1, 6);
      repeat (n) push_byte($urandom_range(0, 3) == 0 ? FlagByte : 8'($urandom));
      gen_flag_pending = 1'b0;
    end else if (pick == 18) begin
      // broken start
      if (!gen_flag_pending) push_byte(FlagByte);
      push_byte(non_flag());
      gen_flag_pending = 1'b0;
    end else begin
      // truncated frame
      send_header(len, chan, code);
    end
  endtask

  initial begin : stimulus_blk
    int unsigned target;
    bit          paused;
    paused        = 1'b0;
    rst           = 1'b1;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no channel assigned yet
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(FlagByte);
    push_byte(8'h41);
    send_frame(8'd7, ChanBcast, CodeBcast, 1'b1);
    send_frame(HeaderLen, ChanNew, CodeNew, 1'b0);
    send_frame(8'd0, 8'h00, 8'h00, 1'b1);
    send_frame(8'd6, ChanNew, CodeBcast, 1'b1);
    settle();
    set_config(6'd46, 1'b1);
    send_frame(8'd6, 8'd46, 8'h00, 1'b0);
    // class stays as decided at the broadcast byte
    send_header(8'd8, 8'd46, 8'h00);
    settle();
    set_config(6'd46, 1'b0);
    send_tail(8'd8, 1'b1);
    send_frame(8'd8, 8'd46, 8'h00, 1'b1);
    settle();
    set_config(6'd63, 1'b1);
    send_frame(8'd6, 8'd63, 8'h00, 1'b1);
    send_frame(8'd6, 8'hFF, 8'h00, 1'b1);
    send_frame(8'd255, ChanBcast, CodeBcast, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: set_config(6'd0, 1'b1);
        1: set_config(6'd46, 1'b1);
        2: set_config(6'($urandom), 1'b0);
        3: set_config(6'($urandom), 1'b1);
        default: set_config(6'd63, 1'b1);
      endcase
      if (ph == 4) idle_on = 1'b0;
      target = queued_cnt + PhaseBytes;
      while (queued_cnt < target) begin
        random_chunk();
        if (ph == 1 && !paused && queued_cnt >= target - PhaseBytes / 2) begin
          // sender holds until the result side has drained
          paused = 1'b1;
          @(posedge clk);
          hold_off = 1'b1;
          repeat (4) @(negedge clk);
          while (due_results.size() != 0) @(negedge clk);
          @(posedge clk);
          hold_off = 1'b0;
        end
      end
    end

    settle();
    if (err_cnt == 0 && due_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_byte_if.sv
hw/rtl/sfd_result_if.sv
hw/rtl/sfd_cfg_if.sv
hw/rtl/sfd_in_stage.sv
hw/rtl/sfd_parser.sv
hw/rtl/sfd_out_fifo.sv
hw/rtl/serial_frame_deframer_filter.sv
tb/tb_serial_frame_deframer_filter.sv
